// ===== src/fault_mode_supervisor_core_macros.svh =====
// Assertion macros shared by the fault mode supervisor checkers.
// Needs nothing else; included by the checker file.
`ifndef FAULT_MODE_SUPERVISOR_CORE_MACROS_SVH
`define FAULT_MODE_SUPERVISOR_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset
`define FMS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define FMS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/fms_pkg.sv =====
// Package for the fault mode supervisor: item types, codes and counter width.
// No dependencies; used by the core and its checker.
`timescale 1ns / 1ps

package fms_pkg;

    // Width of the wrapping statistics counters
    localparam int COUNTER_WIDTH = 32;

    typedef logic [COUNTER_WIDTH-1:0] t_cnt;
    typedef logic [2:0]               t_code3;
    typedef logic [3:0]               t_reason;

    // Operation codes
    localparam t_code3 OP_SAMPLE   = 3'd0;
    localparam t_code3 OP_NOMINAL  = 3'd1;
    localparam t_code3 OP_SAFE     = 3'd2;
    localparam t_code3 OP_DEGRADED = 3'd3;
    localparam t_code3 OP_REBOOT   = 3'd4;
    localparam t_code3 OP_REINIT   = 3'd5;

    // Mode codes
    localparam t_code3 MD_BOOT     = 3'd0;
    localparam t_code3 MD_NOMINAL  = 3'd1;
    localparam t_code3 MD_SAFE     = 3'd2;
    localparam t_code3 MD_DEGRADED = 3'd3;
    localparam t_code3 MD_REBOOT   = 3'd4;

    // Fault recommendation codes, severity rises with value
    localparam t_code3 REC_LOG       = 3'd0;
    localparam t_code3 REC_DISABLE   = 3'd3;
    localparam t_code3 REC_SAFE      = 3'd4;
    localparam t_code3 REC_REBOOT    = 3'd5;

    // Transition reason codes
    localparam t_reason RSN_BOOT        = 4'd0;
    localparam t_reason RSN_NOMINAL     = 4'd1;
    localparam t_reason RSN_FLT_REBOOT  = 4'd2;
    localparam t_reason RSN_FLT_SAFE    = 4'd3;
    localparam t_reason RSN_FLT_DISABLE = 4'd4;

    typedef struct packed {
        logic [2:0] op;
        logic [2:0] recommendation;
        logic       last_of_tick;
        logic [3:0] reason_code;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  mode;
        logic [3:0]  trans_reason;
        logic [31:0] transitions_count;
        logic [31:0] safe_entries_count;
        logic [31:0] safe_exits_count;
        logic [31:0] degrade_count;
        logic [31:0] reboot_request_count;
        logic        reboot_fire;
    } t_out_item;

endpackage

// ===== src/fault_mode_supervisor_core.sv =====
// Fault mode supervisor: mode tracking, tick decisions and statistics counters.
// Depends on fms_pkg.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) takes one item per
//   cycle while o_in_ready is high: a fault sample or a mode command. Output
//   channel (o_out_valid / i_out_ready / o_out_data) returns one result for
//   every item except a fault sample that does not end a tick.
//   A result is registered: on accept it enters the output register, or the
//   skid register when the output register cannot take it. Throughput: one
//   item per cycle while o_in_ready is high, set by the single register update
//   of mode, reason, worst recommendation and counters. Stall: a two-entry
//   output (result register plus skid register) keeps accepting while one
//   result waits; o_in_ready drops only when both are full. Results keep order.
//   Reset (i_rst_n low, synchronous): mode boot, reason boot, worst
//   recommendation log, counters zero, output empty. A reinit item does the
//   same to the supervisor state and also returns a result.
`timescale 1ns / 1ps

module fault_mode_supervisor_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  fms_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output fms_pkg::t_out_item o_out_data
);

    // Supervisor state
    logic [2:0]      r_mode,  n_mode;
    logic [3:0]      r_reason, n_reason;
    logic [2:0]      r_worst, n_worst;
    fms_pkg::t_cnt   r_trans, n_trans;
    fms_pkg::t_cnt   r_sent,  n_sent;
    fms_pkg::t_cnt   r_sexit, n_sexit;
    fms_pkg::t_cnt   r_degr,  n_degr;
    fms_pkg::t_cnt   r_rboot, n_rboot;

    // Output register and skid register
    logic               r_out_valid, r_skid_valid;
    fms_pkg::t_out_item r_out, r_skid;

    logic               accept;
    logic               has_result;
    logic               fire;
    logic               take;
    logic [2:0]         target;
    logic [3:0]         target_reason;
    logic [2:0]         rec_eff;
    logic [2:0]         worst_new;
    fms_pkg::t_out_item result;
    logic               out_free;
    logic               push;

    assign o_in_ready = !r_skid_valid;
    assign accept     = i_in_valid && o_in_ready;

    // Map invalid recommendations to log and fold into the running worst
    always_comb begin
        rec_eff   = (i_in_data.recommendation > fms_pkg::REC_REBOOT) ?
                    fms_pkg::REC_LOG : i_in_data.recommendation;
        worst_new = (rec_eff > r_worst) ? rec_eff : r_worst;
    end

    // Decide the transition for this item
    always_comb begin
        has_result    = 1'b1;
        fire          = 1'b0;
        take          = 1'b0;
        target        = r_mode;
        target_reason = r_reason;
        n_worst       = r_worst;
        case (i_in_data.op)
            fms_pkg::OP_SAMPLE: begin
                if (!i_in_data.last_of_tick) begin
                    has_result = 1'b0;
                    n_worst    = worst_new;
                end else begin
                    n_worst = fms_pkg::REC_LOG;
                    if (r_mode == fms_pkg::MD_REBOOT) begin
                        fire = 1'b1;
                    end else if (worst_new == fms_pkg::REC_REBOOT) begin
                        take          = 1'b1;
                        target        = fms_pkg::MD_REBOOT;
                        target_reason = fms_pkg::RSN_FLT_REBOOT;
                    end else if (worst_new == fms_pkg::REC_SAFE) begin
                        take          = (r_mode != fms_pkg::MD_SAFE);
                        target        = fms_pkg::MD_SAFE;
                        target_reason = fms_pkg::RSN_FLT_SAFE;
                    end else if (worst_new == fms_pkg::REC_DISABLE) begin
                        take          = (r_mode != fms_pkg::MD_DEGRADED) &&
                                        (r_mode != fms_pkg::MD_SAFE);
                        target        = fms_pkg::MD_DEGRADED;
                        target_reason = fms_pkg::RSN_FLT_DISABLE;
                    end else if (r_mode == fms_pkg::MD_SAFE ||
                                 r_mode == fms_pkg::MD_DEGRADED) begin
                        take          = 1'b1;
                        target        = fms_pkg::MD_NOMINAL;
                        target_reason = fms_pkg::RSN_NOMINAL;
                    end
                end
            end
            fms_pkg::OP_NOMINAL: begin
                take          = (r_mode != fms_pkg::MD_NOMINAL);
                target        = fms_pkg::MD_NOMINAL;
                target_reason = fms_pkg::RSN_NOMINAL;
            end
            fms_pkg::OP_SAFE: begin
                take          = (r_mode != fms_pkg::MD_SAFE);
                target        = fms_pkg::MD_SAFE;
                target_reason = i_in_data.reason_code;
            end
            fms_pkg::OP_DEGRADED: begin
                take          = (r_mode != fms_pkg::MD_DEGRADED) &&
                                (r_mode != fms_pkg::MD_SAFE);
                target        = fms_pkg::MD_DEGRADED;
                target_reason = i_in_data.reason_code;
            end
            fms_pkg::OP_REBOOT: begin
                take          = (r_mode != fms_pkg::MD_REBOOT);
                target        = fms_pkg::MD_REBOOT;
                target_reason = i_in_data.reason_code;
            end
            default: begin
            end
        endcase
    end

    // Apply the transition and bump counters
    always_comb begin
        n_mode   = r_mode;
        n_reason = r_reason;
        n_trans  = r_trans;
        n_sent   = r_sent;
        n_sexit  = r_sexit;
        n_degr   = r_degr;
        n_rboot  = r_rboot;
        if (i_in_data.op == fms_pkg::OP_REINIT) begin
            n_mode   = fms_pkg::MD_BOOT;
            n_reason = fms_pkg::RSN_BOOT;
            n_trans  = '0;
            n_sent   = '0;
            n_sexit  = '0;
            n_degr   = '0;
            n_rboot  = '0;
        end else if (take) begin
            n_mode   = target;
            n_reason = target_reason;
            n_trans  = r_trans + fms_pkg::t_cnt'(1);
            if (r_mode != fms_pkg::MD_SAFE && target == fms_pkg::MD_SAFE) begin
                n_sent = r_sent + fms_pkg::t_cnt'(1);
            end
            if (r_mode == fms_pkg::MD_SAFE && target == fms_pkg::MD_NOMINAL) begin
                n_sexit = r_sexit + fms_pkg::t_cnt'(1);
            end
            if (r_mode != fms_pkg::MD_DEGRADED &&
                target == fms_pkg::MD_DEGRADED) begin
                n_degr = r_degr + fms_pkg::t_cnt'(1);
            end
            if (target == fms_pkg::MD_REBOOT) begin
                n_rboot = r_rboot + fms_pkg::t_cnt'(1);
            end
        end
    end

    // Build the result from the state after the item
    always_comb begin
        result.mode                 = n_mode;
        result.trans_reason         = n_reason;
        result.transitions_count    = 32'(n_trans);
        result.safe_entries_count   = 32'(n_sent);
        result.safe_exits_count     = 32'(n_sexit);
        result.degrade_count        = 32'(n_degr);
        result.reboot_request_count = 32'(n_rboot);
        result.reboot_fire          = fire;
    end

    // Hold state, advance on accept
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= fms_pkg::MD_BOOT;
            r_reason <= fms_pkg::RSN_BOOT;
            r_worst  <= fms_pkg::REC_LOG;
            r_trans  <= '0;
            r_sent   <= '0;
            r_sexit  <= '0;
            r_degr   <= '0;
            r_rboot  <= '0;
        end else if (accept) begin
            r_mode   <= n_mode;
            r_reason <= n_reason;
            r_worst  <= (i_in_data.op == fms_pkg::OP_REINIT) ? fms_pkg::REC_LOG : n_worst;
            r_trans  <= n_trans;
            r_sent   <= n_sent;
            r_sexit  <= n_sexit;
            r_degr   <= n_degr;
            r_rboot  <= n_rboot;
        end
    end

    assign out_free = !r_out_valid || i_out_ready;
    assign push     = accept && has_result;

    // Output and skid registers: keep results in order
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= push;
            end else begin
                r_out_valid  <= push;
            end
        end else if (push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
                if (push) begin
                    r_skid <= result;
                end
            end else if (push) begin
                r_out <= result;
            end
        end else if (push) begin
            r_skid <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== src/fault_mode_supervisor_core_checker.sv =====
// Port-level checker for the fault mode supervisor, bound to the top level.
// Depends on fms_pkg and fault_mode_supervisor_core_macros.svh.
`timescale 1ns / 1ps
`include "fault_mode_supervisor_core_macros.svh"

module fault_mode_supervisor_core_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input fms_pkg::t_in_item  i_in_data,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input fms_pkg::t_out_item o_out_data
);

    // A stalled result holds its value
    `FMS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data), "stalled result changed")

    // Reboot fires only while reboot is pending
    `FMS_ASSERT_IMPL(a_fire_mode, i_clk, i_rst_n, o_out_valid && o_out_data.reboot_fire, o_out_data.mode == fms_pkg::MD_REBOOT, "reboot fired outside reboot pending")

    // Boot mode means no transition since reset or reinit
    `FMS_ASSERT_IMPL(a_boot_clean, i_clk, i_rst_n, o_out_valid && o_out_data.mode == fms_pkg::MD_BOOT, o_out_data.transitions_count == 32'd0 && o_out_data.trans_reason == fms_pkg::RSN_BOOT && o_out_data.reboot_request_count == 32'd0, "boot mode with history")

    // Input stalls only behind a held result
    `FMS_ASSERT_IMPL(a_ready_skid, i_clk, i_rst_n, !o_in_ready, o_out_valid, "input stalled with empty output")

endmodule

bind fault_mode_supervisor_core fault_mode_supervisor_core_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

// ===== tb/sv/tb.sv =====
// Self-checking testbench for fault_mode_supervisor_core: directed and random items
// are checked against a built-in mode and counter predictor. Depends on fms_pkg.
`timescale 1ns / 1ps

module tb;

    localparam int ITEM_TARGET  = 1100;
    localparam int CALM_TAIL    = 150;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    fms_pkg::t_in_item  i_in_data = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    fms_pkg::t_out_item o_out_data;

    fault_mode_supervisor_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Items waiting to be driven, and status results waiting to be seen
    fms_pkg::t_in_item  item_backlog[$];
    fms_pkg::t_out_item status_due[$];

    // Predicted supervisor state
    fms_pkg::t_code3  sv_mode;
    fms_pkg::t_reason sv_reason;
    fms_pkg::t_code3  sv_worst;
    fms_pkg::t_cnt    n_trans, n_safe_in, n_safe_out, n_degrade, n_reboot;

    bit fail_seen = 1'b0;
    bit in_taken = 1'b0;
    int stall_cycles = 0;
    int in_hold = 0;
    int out_hold = 0;

    task automatic clear_supervisor();
        sv_mode   = fms_pkg::MD_BOOT;
        sv_reason = fms_pkg::RSN_BOOT;
        sv_worst  = fms_pkg::REC_LOG;
        n_trans   = '0;
        n_safe_in = '0;
        n_safe_out = '0;
        n_degrade = '0;
        n_reboot  = '0;
    endtask

    // Take a transition unless already there; degraded is refused from safe
    task automatic enter_mode(input fms_pkg::t_code3 to, input fms_pkg::t_reason why);
        if (sv_mode == to || (to == fms_pkg::MD_DEGRADED && sv_mode == fms_pkg::MD_SAFE))
            return;
        n_trans = n_trans + fms_pkg::t_cnt'(1);
        if (to == fms_pkg::MD_SAFE)
            n_safe_in = n_safe_in + fms_pkg::t_cnt'(1);
        if (sv_mode == fms_pkg::MD_SAFE && to == fms_pkg::MD_NOMINAL)
            n_safe_out = n_safe_out + fms_pkg::t_cnt'(1);
        if (to == fms_pkg::MD_DEGRADED)
            n_degrade = n_degrade + fms_pkg::t_cnt'(1);
        if (to == fms_pkg::MD_REBOOT)
            n_reboot = n_reboot + fms_pkg::t_cnt'(1);
        sv_mode   = to;
        sv_reason = why;
    endtask

    // Advance the predictor by one item and queue the status it produces
    task automatic supervise(input fms_pkg::t_in_item it);
        fms_pkg::t_code3    rec;
        logic               fire;
        fms_pkg::t_out_item st;
        rec  = (it.recommendation > fms_pkg::REC_REBOOT) ? fms_pkg::REC_LOG
                                                         : it.recommendation;
        fire = 1'b0;
        case (it.op)
            fms_pkg::OP_SAMPLE: begin
                if (rec > sv_worst)
                    sv_worst = rec;
                if (!it.last_of_tick)
                    return;
                if (sv_mode == fms_pkg::MD_REBOOT)
                    fire = 1'b1;
                else if (sv_worst == fms_pkg::REC_REBOOT)
                    enter_mode(fms_pkg::MD_REBOOT, fms_pkg::RSN_FLT_REBOOT);
                else if (sv_worst == fms_pkg::REC_SAFE)
                    enter_mode(fms_pkg::MD_SAFE, fms_pkg::RSN_FLT_SAFE);
                else if (sv_worst == fms_pkg::REC_DISABLE)
                    enter_mode(fms_pkg::MD_DEGRADED, fms_pkg::RSN_FLT_DISABLE);
                else if (sv_mode == fms_pkg::MD_SAFE || sv_mode == fms_pkg::MD_DEGRADED)
                    enter_mode(fms_pkg::MD_NOMINAL, fms_pkg::RSN_NOMINAL);
                sv_worst = fms_pkg::REC_LOG;
            end
            fms_pkg::OP_NOMINAL:  enter_mode(fms_pkg::MD_NOMINAL, fms_pkg::RSN_NOMINAL);
            fms_pkg::OP_SAFE:     enter_mode(fms_pkg::MD_SAFE, it.reason_code);
            fms_pkg::OP_DEGRADED: enter_mode(fms_pkg::MD_DEGRADED, it.reason_code);
            fms_pkg::OP_REBOOT:   enter_mode(fms_pkg::MD_REBOOT, it.reason_code);
            fms_pkg::OP_REINIT:   clear_supervisor();
            default: ;
        endcase
        st.mode                 = sv_mode;
        st.trans_reason         = sv_reason;
        st.transitions_count    = 32'(n_trans);
        st.safe_entries_count   = 32'(n_safe_in);
        st.safe_exits_count     = 32'(n_safe_out);
        st.degrade_count        = 32'(n_degrade);
        st.reboot_request_count = 32'(n_reboot);
        st.reboot_fire          = fire;
        status_due.push_back(st);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
            fail_seen = 1'b1;
        end
    endtask

    // Sample both channels at the rising edge; inputs first so a same-edge result still
    // finds its expectation
    always @(posedge i_clk) begin
        fms_pkg::t_out_item want;
        in_taken <= i_rst_n && i_in_valid && o_in_ready;
        if (!i_rst_n) begin
            clear_supervisor();
        end else begin
            if (i_in_valid && o_in_ready)
                supervise(i_in_data);
            if (o_out_valid && i_out_ready) begin
                if (status_due.size() == 0) begin
                    $display("%0t ns: unexpected result, expected none, got %h",
                             $time, o_out_data);
                    fail_seen = 1'b1;
                end else begin
                    want = status_due.pop_front();
                    check_field("mode", 32'(want.mode), 32'(o_out_data.mode));
                    check_field("trans_reason", 32'(want.trans_reason),
                                32'(o_out_data.trans_reason));
                    check_field("transitions_count", want.transitions_count,
                                o_out_data.transitions_count);
                    check_field("safe_entries_count", want.safe_entries_count,
                                o_out_data.safe_entries_count);
                    check_field("safe_exits_count", want.safe_exits_count,
                                o_out_data.safe_exits_count);
                    check_field("degrade_count", want.degrade_count,
                                o_out_data.degrade_count);
                    check_field("reboot_request_count", want.reboot_request_count,
                                o_out_data.reboot_request_count);
                    check_field("reboot_fire", 32'(want.reboot_fire),
                                32'(o_out_data.reboot_fire));
                end
            end
        end
        // Count cycles in which no item moves on either side
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    // Feed items at the falling edge, with random idle bursts until the calm tail
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && !in_taken) begin
            // hold the item until it is accepted
        end else if (in_hold > 0) begin
            in_hold--;
            i_in_valid <= 1'b0;
        end else if (item_backlog.size() > CALM_TAIL && $urandom_range(0, 9) == 0) begin
            in_hold = $urandom_range(1, 16) - 1;
            i_in_valid <= 1'b0;
        end else if (item_backlog.size() > 0) begin
            i_in_data  <= item_backlog.pop_front();
            i_in_valid <= 1'b1;
        end else begin
            i_in_valid <= 1'b0;
        end
    end

    // Stall the result side in random bursts, none in the calm tail
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (out_hold > 0) begin
            out_hold--;
            i_out_ready <= 1'b0;
        end else if (item_backlog.size() > CALM_TAIL && $urandom_range(0, 7) == 0) begin
            out_hold = $urandom_range(1, 16) - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    task automatic queue_item(input fms_pkg::t_code3 op, input fms_pkg::t_code3 rec,
                              input logic last, input fms_pkg::t_reason why);
        fms_pkg::t_in_item it;
        it.op             = op;
        it.recommendation = rec;
        it.last_of_tick   = last;
        it.reason_code    = why;
        item_backlog.push_back(it);
    endtask

    function automatic fms_pkg::t_code3 pick_recommendation();
        if ($urandom_range(0, 3) == 0)
            return fms_pkg::t_code3'($urandom_range(0, 7));
        return fms_pkg::t_code3'($urandom_range(0, 2));
    endfunction

    function automatic fms_pkg::t_code3 pick_command();
        return fms_pkg::t_code3'($urandom_range(fms_pkg::OP_NOMINAL, fms_pkg::OP_REBOOT));
    endfunction

    function automatic logic pick_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    function automatic fms_pkg::t_reason pick_reason();
        return fms_pkg::t_reason'($urandom_range(0, 15));
    endfunction

    task automatic build_random_items();
        int kind, len;
        while (item_backlog.size() < ITEM_TARGET) begin
            kind = $urandom_range(0, 99);
            if (kind < 70) begin
                // well-formed tick, sometimes with a command in the middle
                len = $urandom_range(1, 4);
                for (int k = 0; k < len; k++) begin
                    if (k == len - 1 && len > 1 && $urandom_range(0, 9) == 0)
                        queue_item(pick_command(), pick_recommendation(), pick_bit(),
                                   pick_reason());
                    queue_item(fms_pkg::OP_SAMPLE, pick_recommendation(), k == len - 1,
                               pick_reason());
                end
            end else if (kind < 90) begin
                queue_item(pick_command(), fms_pkg::t_code3'($urandom_range(0, 7)),
                           pick_bit(), pick_reason());
            end else if (kind < 94) begin
                // undefined operations
                queue_item(fms_pkg::t_code3'($urandom_range(6, 7)),
                           fms_pkg::t_code3'($urandom_range(0, 7)), pick_bit(),
                           pick_reason());
            end else if (kind < 96) begin
                queue_item(fms_pkg::OP_REINIT, fms_pkg::t_code3'($urandom_range(0, 7)),
                           pick_bit(), pick_reason());
            end else begin
                // broken tick: a sample that never closes, its worst carries on
                queue_item(fms_pkg::OP_SAMPLE, fms_pkg::t_code3'($urandom_range(0, 7)),
                           1'b0, pick_reason());
            end
        end
    endtask

    // Directed items, then the random run, then drain and report
    initial begin
        queue_item(fms_pkg::OP_SAMPLE, 3'd0, 1'b1, 4'd0);          // benign tick in boot
        queue_item(fms_pkg::OP_NOMINAL, 3'd0, 1'b0, 4'd15);        // boot to nominal
        queue_item(fms_pkg::OP_NOMINAL, 3'd7, 1'b1, 4'd3);         // already nominal
        queue_item(fms_pkg::OP_SAMPLE, fms_pkg::REC_DISABLE, 1'b0, 4'd15);
        queue_item(fms_pkg::OP_SAMPLE, 3'd1, 1'b1, 4'd0);          // worst disable: degraded
        queue_item(fms_pkg::OP_SAMPLE, 3'd0, 1'b1, 4'd0);          // benign: back to nominal
        queue_item(fms_pkg::OP_SAMPLE, fms_pkg::REC_SAFE, 1'b1, 4'd0);    // enter safe
        queue_item(fms_pkg::OP_SAMPLE, fms_pkg::REC_DISABLE, 1'b1, 4'd0); // ignored in safe
        queue_item(fms_pkg::OP_DEGRADED, 3'd0, 1'b0, 4'd15);       // command ignored in safe
        queue_item(fms_pkg::OP_SAMPLE, 3'd2, 1'b1, 4'd0);          // safe exit
        queue_item(fms_pkg::OP_SAFE, 3'd0, 1'b0, 4'd15);
        queue_item(fms_pkg::OP_SAFE, 3'd0, 1'b0, 4'd0);            // already safe
        queue_item(fms_pkg::OP_NOMINAL, 3'd0, 1'b0, 4'd0);
        queue_item(fms_pkg::OP_DEGRADED, 3'd0, 1'b0, 4'd9);
        queue_item(fms_pkg::OP_SAMPLE, 3'd7, 1'b0, 4'd0);          // out-of-range recommendations
        queue_item(fms_pkg::OP_SAMPLE, 3'd6, 1'b1, 4'd0);
        queue_item(fms_pkg::OP_SAMPLE, fms_pkg::REC_REBOOT, 1'b1, 4'd0); // arm reboot, no fire
        queue_item(fms_pkg::OP_SAMPLE, 3'd0, 1'b1, 4'd0);          // fire
        queue_item(fms_pkg::OP_REBOOT, 3'd0, 1'b0, 4'd10);         // already pending
        queue_item(fms_pkg::OP_SAMPLE, fms_pkg::REC_REBOOT, 1'b0, 4'd0);
        queue_item(fms_pkg::OP_SAFE, 3'd0, 1'b0, 4'd6);            // command inside a tick
        queue_item(fms_pkg::OP_SAMPLE, 3'd0, 1'b1, 4'd0);          // carried worst: reboot
        queue_item(3'd6, 3'd5, 1'b1, 4'd15);
        queue_item(3'd7, 3'd0, 1'b0, 4'd0);
        queue_item(fms_pkg::OP_SAMPLE, fms_pkg::REC_SAFE, 1'b0, 4'd0);
        queue_item(fms_pkg::OP_REINIT, 3'd0, 1'b0, 4'd0);          // also drops the worst
        queue_item(fms_pkg::OP_SAMPLE, 3'd0, 1'b1, 4'd0);
        queue_item(fms_pkg::OP_REBOOT, 3'd0, 1'b0, 4'd15);         // boot to reboot pending
        build_random_items();

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        do
            @(negedge i_clk);
        while (item_backlog.size() != 0 || i_in_valid || status_due.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        if (!fail_seen && status_due.size() == 0)
            $display("fault_mode_supervisor_core: match");
        else
            $display("fault_mode_supervisor_core: mismatch");
        $finish;
    end

    // End the run when no item has moved for too long
    initial begin
        while (stall_cycles < STALL_LIMIT)
            @(posedge i_clk);
        $display("%0t ns: no item accepted for %0d cycles", $time, STALL_LIMIT);
        $display("fault_mode_supervisor_core: mismatch");
        $finish;
    end

endmodule
